@@ rtl/amc_pkg.sv @@
// Package for the activity mode controller: item, result and configuration
// types, mode encodings, register indexes and reset values.
// Depends on nothing; every other file in the block imports it.
`default_nettype none

package amc_pkg;

    localparam int IDLE_COUNT_BITS_DEF = 19;
    localparam int TIMEOUT_BITS        = 19;
    localparam int SECONDS_BITS        = 16;
    localparam int HOLD_MS_BITS        = 10;
    localparam int CFG_ADDR_BITS       = 5;
    localparam int CFG_DATA_BITS       = 32;
    localparam int S_TDATA_BITS        = 8;
    localparam int M_TDATA_BITS        = 32;

    localparam logic [HOLD_MS_BITS-1:0] MS_PER_SECOND   = HOLD_MS_BITS'(1000);
    localparam logic [SECONDS_BITS-1:0] HOLD_SECONDS_MAX = '1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ACTIVE_TO   = 3'd0;
    localparam logic [2:0] REG_INTERACT_TO = 3'd1;
    localparam logic [2:0] REG_SLEEP_TO    = 3'd2;
    localparam logic [2:0] REG_CARD_EN     = 3'd3;
    localparam logic [2:0] REG_MOTION_EN   = 3'd4;
    localparam logic [2:0] REG_SNACK       = 3'd5;
    localparam logic [2:0] REG_MEAL        = 3'd6;
    localparam logic [2:0] REG_FEAST       = 3'd7;

    localparam logic [TIMEOUT_BITS-1:0] ACTIVE_TO_RST   = TIMEOUT_BITS'(30000);
    localparam logic [TIMEOUT_BITS-1:0] INTERACT_TO_RST = TIMEOUT_BITS'(10000);
    localparam logic [TIMEOUT_BITS-1:0] SLEEP_TO_RST    = TIMEOUT_BITS'(300000);
    localparam logic [SECONDS_BITS-1:0] SNACK_RST       = SECONDS_BITS'(3);
    localparam logic [SECONDS_BITS-1:0] MEAL_RST        = SECONDS_BITS'(10);
    localparam logic [SECONDS_BITS-1:0] FEAST_RST       = SECONDS_BITS'(30);

    // Mode codes as they appear on the result word.
    localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_CODE_ACTIVE   = 3'd1;
    localparam logic [2:0] MODE_CODE_INTERACT = 3'd2;
    localparam logic [2:0] MODE_CODE_SLEEP    = 3'd3;
    localparam logic [2:0] MODE_CODE_ALERT    = 3'd4;

    localparam logic [1:0] MOTION_NONE  = 2'd0;
    localparam logic [1:0] MOTION_FALL  = 2'd1;
    localparam logic [1:0] MOTION_SHAKE = 2'd2;

    localparam logic [1:0] LEVEL_TAP   = 2'd0;
    localparam logic [1:0] LEVEL_SNACK = 2'd1;
    localparam logic [1:0] LEVEL_MEAL  = 2'd2;
    localparam logic [1:0] LEVEL_FEAST = 2'd3;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_ACTIVE   = 5'b00010,
        MODE_INTERACT = 5'b00100,
        MODE_SLEEP    = 5'b01000,
        MODE_ALERT    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [TIMEOUT_BITS-1:0] active_to;
        logic [TIMEOUT_BITS-1:0] interact_to;
        logic [TIMEOUT_BITS-1:0] sleep_to;
        logic                    card_en;
        logic                    motion_en;
        logic [SECONDS_BITS-1:0] snack;
        logic [SECONDS_BITS-1:0] meal;
        logic [SECONDS_BITS-1:0] feast;
    } t_cfg;

    // Lowest bit last in the declaration, so touch_seen sits at bit 0.
    typedef struct packed {
        logic [1:0] motion_event;
        logic       card_on;
        logic       touch_seen;
    } t_item;

    typedef struct packed {
        logic [1:0]              motion_report;
        logic [1:0]              feed_level;
        logic [SECONDS_BITS-1:0] feed_seconds;
        logic                    feed_report;
        logic                    touch_report;
        logic                    mode_changed;
        logic [2:0]              mode_now;
    } t_result;

    typedef struct packed {
        logic [HOLD_MS_BITS-1:0] ms_part;
        logic [SECONDS_BITS-1:0] seconds;
    } t_hold;

    function automatic logic [2:0] mode_code(input t_mode mode);
        logic [2:0] code;
        case (mode)
            MODE_IDLE:     code = MODE_CODE_IDLE;
            MODE_ACTIVE:   code = MODE_CODE_ACTIVE;
            MODE_INTERACT: code = MODE_CODE_INTERACT;
            MODE_SLEEP:    code = MODE_CODE_SLEEP;
            MODE_ALERT:    code = MODE_CODE_ALERT;
            default:       code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/activity_mode_controller_unit.sv @@
// Top level of the activity mode controller: input register, mode and timer
// state, result register. Uses amc_pkg, amc_cfg and amc_mode_logic.
//
// Channel   Direction  Handshake              Contents
// s         in         i_s_tvalid/o_s_tready  one tick word: touch, card, motion
// m         out        o_m_tvalid/i_m_tready  one result word per tick word
// apb       in/out     psel/penable/pready    eight configuration registers
//
// One word is accepted every cycle while the result register is not stalled.
// The input register feeds one pass of mode logic into the result register,
// and the state is updated at the edge at which the result is loaded.
// A stalled result register holds the word behind it in the input register.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module activity_mode_controller_unit #(
    parameter int IDLE_COUNT_BITS = amc_pkg::IDLE_COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [0] touch_seen, [1] card_on, [3:2] motion_event, [7:4] unused
    input  wire logic [amc_pkg::S_TDATA_BITS-1:0]  i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [2:0] mode_now, [3] mode_changed, [4] touch_report, [5] feed_report,
    // [21:6] feed_seconds, [23:22] feed_level, [25:24] motion_report, [31:26] zero
    output logic      [amc_pkg::M_TDATA_BITS-1:0]  o_m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [amc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [amc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [amc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready
);
    import amc_pkg::*;

    localparam int ITEM_BITS   = $bits(t_item);
    localparam int RESULT_BITS = $bits(t_result);

    t_cfg                       cfg;
    logic                       r_in_valid;
    t_item                      r_in;
    logic                       r_out_valid;
    t_result                    r_out;
    t_mode                      r_mode;
    logic [IDLE_COUNT_BITS-1:0] r_idle_ms;
    logic                       r_card_last;
    t_hold                      r_hold;

    t_mode                      n_mode;
    logic [IDLE_COUNT_BITS-1:0] n_idle_ms;
    logic                       n_card_last;
    t_hold                      n_hold;
    t_result                    n_out;
    logic                       step;

    amc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    amc_mode_logic #(
        .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
    ) u_logic (
        .i_cfg       (cfg),
        .i_item      (r_in),
        .i_mode      (r_mode),
        .i_idle_ms   (r_idle_ms),
        .i_card_last (r_card_last),
        .i_hold      (r_hold),
        .o_mode      (n_mode),
        .o_idle_ms   (n_idle_ms),
        .o_card_last (n_card_last),
        .o_hold      (n_hold),
        .o_result    (n_out)
    );

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_BITS - RESULT_BITS)'(0), r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= t_item'(i_s_tdata[ITEM_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_idle_ms   <= '0;
            r_card_last <= 1'b0;
            r_hold      <= '0;
        end else if (step) begin
            r_mode      <= n_mode;
            r_idle_ms   <= n_idle_ms;
            r_card_last <= n_card_last;
            r_hold      <= n_hold;
        end
    end

    a_hold_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold.ms_part < MS_PER_SECOND)
        else $error("hold millisecond count out of range");

    a_feed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.feed_report) |->
            (r_out.feed_seconds == '0 && r_out.feed_level == LEVEL_TAP))
        else $error("feed fields set without a feed report");

    a_mode_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.mode_now == mode_code(r_mode)))
        else $error("reported mode differs from stored mode");

    a_touch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in.touch_seen) |=> (r_idle_ms == '0))
        else $error("touch did not clear the idle timer");

endmodule

`default_nettype wire

@@ rtl/amc_cfg.sv @@
// Configuration register file of the activity mode controller, APB-style port.
// Depends on amc_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module amc_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [amc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [amc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [amc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    output amc_pkg::t_cfg                          o_cfg
);
    import amc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_to   <= ACTIVE_TO_RST;
            r_cfg.interact_to <= INTERACT_TO_RST;
            r_cfg.sleep_to    <= SLEEP_TO_RST;
            r_cfg.card_en     <= 1'b1;
            r_cfg.motion_en   <= 1'b1;
            r_cfg.snack       <= SNACK_RST;
            r_cfg.meal        <= MEAL_RST;
            r_cfg.feast       <= FEAST_RST;
        end else if (wr_en) begin
            case (reg_index)
                REG_ACTIVE_TO:   r_cfg.active_to   <= pwdata[TIMEOUT_BITS-1:0];
                REG_INTERACT_TO: r_cfg.interact_to <= pwdata[TIMEOUT_BITS-1:0];
                REG_SLEEP_TO:    r_cfg.sleep_to    <= pwdata[TIMEOUT_BITS-1:0];
                REG_CARD_EN:     r_cfg.card_en     <= pwdata[0];
                REG_MOTION_EN:   r_cfg.motion_en   <= pwdata[0];
                REG_SNACK:       r_cfg.snack       <= pwdata[SECONDS_BITS-1:0];
                REG_MEAL:        r_cfg.meal        <= pwdata[SECONDS_BITS-1:0];
                REG_FEAST:       r_cfg.feast       <= pwdata[SECONDS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_ACTIVE_TO:   prdata = CFG_DATA_BITS'(r_cfg.active_to);
            REG_INTERACT_TO: prdata = CFG_DATA_BITS'(r_cfg.interact_to);
            REG_SLEEP_TO:    prdata = CFG_DATA_BITS'(r_cfg.sleep_to);
            REG_CARD_EN:     prdata = CFG_DATA_BITS'(r_cfg.card_en);
            REG_MOTION_EN:   prdata = CFG_DATA_BITS'(r_cfg.motion_en);
            REG_SNACK:       prdata = CFG_DATA_BITS'(r_cfg.snack);
            REG_MEAL:        prdata = CFG_DATA_BITS'(r_cfg.meal);
            REG_FEAST:       prdata = CFG_DATA_BITS'(r_cfg.feast);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/amc_mode_logic.sv @@
// Next-state and result logic for one millisecond tick of the controller.
// Purely combinational; depends on amc_pkg for the types and encodings.
`default_nettype none

module amc_mode_logic #(
    parameter int IDLE_COUNT_BITS = amc_pkg::IDLE_COUNT_BITS_DEF
) (
    input  wire amc_pkg::t_cfg               i_cfg,
    input  wire amc_pkg::t_item              i_item,
    input  wire amc_pkg::t_mode              i_mode,
    input  wire logic [IDLE_COUNT_BITS-1:0]  i_idle_ms,
    input  wire logic                        i_card_last,
    input  wire amc_pkg::t_hold              i_hold,
    output amc_pkg::t_mode                   o_mode,
    output logic      [IDLE_COUNT_BITS-1:0]  o_idle_ms,
    output logic                             o_card_last,
    output amc_pkg::t_hold                   o_hold,
    output amc_pkg::t_result                 o_result
);
    import amc_pkg::*;

    localparam int CMP_BITS = (IDLE_COUNT_BITS > TIMEOUT_BITS) ? IDLE_COUNT_BITS : TIMEOUT_BITS;
    localparam logic [IDLE_COUNT_BITS-1:0] IDLE_MAX = '1;

    t_mode                   mode;
    logic [IDLE_COUNT_BITS-1:0] idle;
    t_hold                   hold;
    logic [HOLD_MS_BITS-1:0] ms_inc;
    logic                    card_rise;
    logic                    card_fall;
    logic [1:0]              level;
    logic [1:0]              motion_rep;
    logic [TIMEOUT_BITS-1:0] timeout;
    logic                    timeout_hit;
    t_mode                   mode_final;

    assign ms_inc    = i_hold.ms_part + HOLD_MS_BITS'(1);
    assign card_rise = i_cfg.card_en && i_item.card_on && !i_card_last;
    assign card_fall = i_cfg.card_en && !i_item.card_on && i_card_last;

    always_comb begin
        mode       = i_mode;
        idle       = (i_idle_ms != IDLE_MAX) ? i_idle_ms + IDLE_COUNT_BITS'(1) : i_idle_ms;
        hold       = i_hold;
        motion_rep = MOTION_NONE;

        if (i_item.touch_seen) begin
            idle = '0;
            case (i_mode)
                MODE_SLEEP:  mode = MODE_IDLE;
                MODE_IDLE:   mode = MODE_ACTIVE;
                MODE_ACTIVE: mode = MODE_INTERACT;
                default:     mode = i_mode;
            endcase
        end

        if (i_cfg.card_en && i_card_last && (i_hold.seconds != HOLD_SECONDS_MAX)) begin
            if (ms_inc == MS_PER_SECOND) begin
                hold.ms_part = '0;
                hold.seconds = i_hold.seconds + SECONDS_BITS'(1);
            end else begin
                hold.ms_part = ms_inc;
            end
        end

        if (card_rise) begin
            hold = '0;
            idle = '0;
            mode = (mode == MODE_SLEEP) ? MODE_IDLE : MODE_INTERACT;
        end

        if (i_cfg.motion_en) begin
            if (i_item.motion_event == MOTION_FALL) begin
                mode       = MODE_ALERT;
                motion_rep = MOTION_FALL;
            end else if (i_item.motion_event == MOTION_SHAKE) begin
                idle       = '0;
                motion_rep = MOTION_SHAKE;
                if (mode == MODE_SLEEP) begin
                    mode = MODE_IDLE;
                end
            end
        end
    end

    always_comb begin
        case (mode)
            MODE_ACTIVE:   timeout = i_cfg.active_to;
            MODE_INTERACT: timeout = i_cfg.interact_to;
            default:       timeout = i_cfg.sleep_to;
        endcase
    end

    assign timeout_hit = CMP_BITS'(idle) >= CMP_BITS'(timeout);

    always_comb begin
        mode_final = mode;
        if (timeout_hit) begin
            case (mode)
                MODE_ACTIVE:   mode_final = MODE_IDLE;
                MODE_INTERACT: mode_final = MODE_ACTIVE;
                MODE_IDLE:     mode_final = MODE_SLEEP;
                default:       mode_final = mode;
            endcase
        end
    end

    always_comb begin
        if (hold.seconds < i_cfg.snack) begin
            level = LEVEL_TAP;
        end else if (hold.seconds < i_cfg.meal) begin
            level = LEVEL_SNACK;
        end else if (hold.seconds < i_cfg.feast) begin
            level = LEVEL_MEAL;
        end else begin
            level = LEVEL_FEAST;
        end
    end

    assign o_mode      = mode_final;
    assign o_idle_ms   = idle;
    assign o_card_last = i_cfg.card_en ? i_item.card_on : i_card_last;
    assign o_hold      = hold;

    assign o_result.mode_now      = mode_code(mode_final);
    assign o_result.mode_changed  = (mode_final != i_mode);
    assign o_result.touch_report  = i_item.touch_seen;
    assign o_result.feed_report   = card_fall;
    assign o_result.feed_seconds  = card_fall ? hold.seconds : '0;
    assign o_result.feed_level    = card_fall ? level : LEVEL_TAP;
    assign o_result.motion_report = motion_rep;

endmodule

`default_nettype wire

@@ tb/activity_mode_controller_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for activity_mode_controller_unit: tick words are streamed in
// under random idling and stalls, and every result word is compared with a predictor.
// Depends on amc_pkg and the activity_mode_controller_unit RTL.

module activity_mode_controller_unit_test;

    import amc_pkg::*;

    localparam int               IDLE_BITS       = IDLE_COUNT_BITS_DEF;
    localparam int               STALL_LIMIT     = 2000;
    localparam int               HOLD_OFF_CYCLES = 64;
    localparam logic [1:0]       MOTION_UNUSED   = 2'd3;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [S_TDATA_BITS-1:0]     i_s_tdata = '0;
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]     o_m_tdata;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]    paddr = '0;
    logic [CFG_DATA_BITS-1:0]    pwdata = '0;
    logic [CFG_DATA_BITS-1:0]    prdata;
    logic                        pready;

    // Predictor state and its copy of the registers.
    t_cfg                        mode_setup = {ACTIVE_TO_RST, INTERACT_TO_RST, SLEEP_TO_RST,
                                               1'b1, 1'b1, SNACK_RST, MEAL_RST, FEAST_RST};
    logic [2:0]                  mode_state = MODE_CODE_IDLE;
    logic [IDLE_BITS-1:0]        idle_count = '0;
    logic                        card_was_present = 1'b0;
    logic [HOLD_MS_BITS-1:0]     hold_ms = '0;
    logic [SECONDS_BITS-1:0]     hold_sec = '0;

    t_item                       tick_queue[$];
    t_result                     expected_results[$];
    logic                        card_level = 1'b0;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          hold_offs_requested = 0;
    int                          hold_offs_served = 0;
    int                          hold_off_left = 0;
    int                          mismatch_count = 0;
    int                          quiet_cycles = 0;

    activity_mode_controller_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result step_mode_model(input t_item tick);
        t_result    res;
        logic [2:0] prev_mode;
        res = '0;
        prev_mode = mode_state;
        if (idle_count != '1) begin
            idle_count = idle_count + 1'b1;
        end
        if (tick.touch_seen) begin
            idle_count = '0;
            case (mode_state)
                MODE_CODE_SLEEP:  mode_state = MODE_CODE_IDLE;
                MODE_CODE_IDLE:   mode_state = MODE_CODE_ACTIVE;
                MODE_CODE_ACTIVE: mode_state = MODE_CODE_INTERACT;
                default: ;
            endcase
        end
        if (mode_setup.card_en) begin
            if (card_was_present && hold_sec != HOLD_SECONDS_MAX) begin
                hold_ms = hold_ms + 1'b1;
                if (hold_ms >= MS_PER_SECOND) begin
                    hold_ms = '0;
                    hold_sec = hold_sec + 1'b1;
                end
            end
            if (tick.card_on && !card_was_present) begin
                hold_ms = '0;
                hold_sec = '0;
                idle_count = '0;
                mode_state = (mode_state == MODE_CODE_SLEEP) ? MODE_CODE_IDLE
                                                             : MODE_CODE_INTERACT;
            end
            if (!tick.card_on && card_was_present) begin
                res.feed_report = 1'b1;
                res.feed_seconds = hold_sec;
                if (hold_sec < mode_setup.snack) begin
                    res.feed_level = LEVEL_TAP;
                end else if (hold_sec < mode_setup.meal) begin
                    res.feed_level = LEVEL_SNACK;
                end else if (hold_sec < mode_setup.feast) begin
                    res.feed_level = LEVEL_MEAL;
                end else begin
                    res.feed_level = LEVEL_FEAST;
                end
            end
            card_was_present = tick.card_on;
        end
        if (mode_setup.motion_en) begin
            if (tick.motion_event == MOTION_FALL) begin
                mode_state = MODE_CODE_ALERT;
                res.motion_report = MOTION_FALL;
            end else if (tick.motion_event == MOTION_SHAKE) begin
                idle_count = '0;
                if (mode_state == MODE_CODE_SLEEP) begin
                    mode_state = MODE_CODE_IDLE;
                end
                res.motion_report = MOTION_SHAKE;
            end
        end
        case (mode_state)
            MODE_CODE_ACTIVE: begin
                if (idle_count >= mode_setup.active_to) mode_state = MODE_CODE_IDLE;
            end
            MODE_CODE_INTERACT: begin
                if (idle_count >= mode_setup.interact_to) mode_state = MODE_CODE_ACTIVE;
            end
            MODE_CODE_IDLE: begin
                if (idle_count >= mode_setup.sleep_to) mode_state = MODE_CODE_SLEEP;
            end
            default: ;
        endcase
        res.mode_now = mode_state;
        res.mode_changed = (mode_state != prev_mode);
        res.touch_report = tick.touch_seen;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_result(input logic [M_TDATA_BITS-1:0] word);
        t_result got;
        t_result want;
        got = word[$bits(t_result)-1:0];
        if (expected_results.size() == 0) begin
            $error("result word %h arrived with nothing expected", word);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("mode_now", want.mode_now, got.mode_now);
            check_field("mode_changed", want.mode_changed, got.mode_changed);
            check_field("touch_report", want.touch_report, got.touch_report);
            check_field("feed_report", want.feed_report, got.feed_report);
            check_field("feed_seconds", want.feed_seconds, got.feed_seconds);
            check_field("feed_level", want.feed_level, got.feed_level);
            check_field("motion_report", want.motion_report, got.motion_report);
        end
    endtask

    // Driver: a word stays offered until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(step_mode_model(i_s_tdata[$bits(t_item)-1:0]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= S_TDATA_BITS'(tick_queue.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and result-side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_result(o_m_tdata);
            end
            if (hold_offs_served != hold_offs_requested) begin
                hold_off_left = HOLD_OFF_CYCLES;
                hold_offs_served++;
            end
            if (hold_off_left != 0) begin
                hold_off_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_BITS'({index, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_ACTIVE_TO:   mode_setup.active_to = value[TIMEOUT_BITS-1:0];
            REG_INTERACT_TO: mode_setup.interact_to = value[TIMEOUT_BITS-1:0];
            REG_SLEEP_TO:    mode_setup.sleep_to = value[TIMEOUT_BITS-1:0];
            REG_CARD_EN:     mode_setup.card_en = value[0];
            REG_MOTION_EN:   mode_setup.motion_en = value[0];
            REG_SNACK:       mode_setup.snack = value[SECONDS_BITS-1:0];
            REG_MEAL:        mode_setup.meal = value[SECONDS_BITS-1:0];
            REG_FEAST:       mode_setup.feast = value[SECONDS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input int active_to, input int interact_to, input int sleep_to,
                               input int card_en, input int motion_en, input int snack,
                               input int meal, input int feast);
        write_register(REG_ACTIVE_TO, active_to);
        write_register(REG_INTERACT_TO, interact_to);
        write_register(REG_SLEEP_TO, sleep_to);
        write_register(REG_CARD_EN, card_en);
        write_register(REG_MOTION_EN, motion_en);
        write_register(REG_SNACK, snack);
        write_register(REG_MEAL, meal);
        write_register(REG_FEAST, feast);
        @(negedge i_clk);
    endtask

    task automatic add_tick(input logic touch, input logic card, input logic [1:0] motion);
        t_item tick;
        tick.touch_seen = touch;
        tick.card_on = card;
        tick.motion_event = motion;
        tick_queue.push_back(tick);
    endtask

    // Mostly plausible activity: touches, card placements and removals, motion and quiet
    // stretches long enough to let the timeouts fire, with some fully random words mixed in.
    task automatic queue_ticks(input int count, input int quiet_max, input bit card_may_change);
        t_item tick;
        int    quiet_left;
        quiet_left = 0;
        repeat (count) begin
            tick = '0;
            if (quiet_left > 0) begin
                quiet_left--;
            end else begin
                case ($urandom_range(9))
                    0: quiet_left = $urandom_range(quiet_max);
                    1, 2: tick.touch_seen = 1'b1;
                    3: tick.motion_event = 2'($urandom_range(3));
                    4: begin
                        if (card_may_change) card_level = !card_level;
                    end
                    5: begin
                        tick = 4'($urandom_range(15));
                        if (card_may_change) card_level = tick.card_on;
                    end
                    default: ;
                endcase
            end
            tick.card_on = card_level;
            tick_queue.push_back(tick);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        while (tick_queue.size() != 0 || i_s_tvalid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers at their reset values: touch ladder, card in interact and in alert,
        // touch and shake while in alert, the unused motion code.
        add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b1, 1'b0, MOTION_NONE);
        add_tick(1'b1, 1'b0, MOTION_NONE);
        add_tick(1'b1, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b1, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_FALL);
        add_tick(1'b1, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_SHAKE);
        add_tick(1'b0, 1'b0, MOTION_UNUSED);
        add_tick(1'b1, 1'b1, MOTION_FALL);
        add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b1, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_NONE);
        wait_for_drain();

        // Short timeouts walk interact down to sleep; each kind of wake-up from sleep;
        // level thresholds out of order.
        apply_setup(2, 2, 3, 1, 1, 0, 5, 0);
        repeat (3) add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b1, 1'b0, MOTION_NONE);
        repeat (3) add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_SHAKE);
        repeat (3) add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b0, 1'b1, MOTION_NONE);
        add_tick(1'b0, 1'b0, MOTION_NONE);
        add_tick(1'b1, 1'b1, MOTION_SHAKE);
        card_level = 1'b1;
        wait_for_drain();

        // A card held for over a second, then removed, under each kind of idling.
        apply_setup(524287, 6, 524287, 1, 1, 1, 2, 65535);
        queue_ticks(252, 12, 1'b0);
        wait_for_drain();
        send_idle_pct = 56;
        queue_ticks(252, 12, 1'b0);
        wait_for_drain();
        send_idle_pct = 0;
        recv_stall_pct = 56;
        queue_ticks(252, 12, 1'b0);
        hold_offs_requested++;
        wait_for_drain();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        queue_ticks(252, 12, 1'b0);
        card_level = 1'b0;
        add_tick(1'b0, 1'b0, MOTION_NONE);
        queue_ticks(6, 12, 1'b1);
        wait_for_drain();

        apply_setup(5, 3, 9, 1, 1, 0, 1, 2);
        queue_ticks(8, 14, 1'b1);
        card_level = 1'b1;
        repeat (5) add_tick(1'b0, 1'b1, MOTION_NONE);
        wait_for_drain();

        // Card handling frozen with a card on the reader; zero timeouts.
        apply_setup(0, 0, 0, 0, 1, 0, 0, 0);
        queue_ticks(8, 6, 1'b1);
        wait_for_drain();

        apply_setup(1, 1, 1, 1, 0, 65535, 65535, 65535);
        queue_ticks(8, 4, 1'b1);
        wait_for_drain();

        apply_setup(7, 4, 12, 1, 1, 0, 2, 1);
        queue_ticks(8, 20, 1'b1);
        wait_for_drain();

        repeat (8) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ activity_mode_controller_unit.f @@
rtl/amc_pkg.sv
rtl/amc_cfg.sv
rtl/amc_mode_logic.sv
rtl/activity_mode_controller_unit.sv
tb/activity_mode_controller_unit_test.sv
